### hw/rtl/aesr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aesr_pkg
// Shared types, the S-box table and GF(2^8) helpers for the AES round.
// ----------------------------------------------------------------------------
package aesr_pkg;

	// 16 state bytes; element 0 is the most significant byte of the 128-bit word.
	typedef logic [0:15][7:0] block_t;

	// Reduction constant of x^8 + x^4 + x^3 + x + 1 without the x^8 term.
	localparam logic [7:0] GF_POLY = 8'h1b;

	// Standard AES S-box.
	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,
		8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,
		8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,
		8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,
		8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,
		8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,
		8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,
		8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,
		8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,
		8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,
		8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,
		8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,
		8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,
		8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,
		8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,
		8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,
		8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	// Multiply by x in GF(2^8).
	function automatic logic [7:0] xtime(input logic [7:0] v);
		xtime = {v[6:0], 1'b0} ^ (v[7] ? GF_POLY : 8'h00);
	endfunction

endpackage
`default_nettype wire

### hw/rtl/aes_encrypt_round_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aes_encrypt_round_top
// One AES encryption round: SubBytes, ShiftRows, MixColumns (skipped when last_round is set), AddRoundKey.
// ----------------------------------------------------------------------------
//  Channel | Handshake            | Payload
//  input   | in_valid / in_stall  | state_high, state_low, key_high, key_low,
//          |                      | last_round
//  output  | out_valid / out_stall| out_high, out_low
//
// Three register stages: input capture, S-box plus row shift, column mix plus
// key add into the output register. One item is accepted per cycle while
// in_stall is low; a stage advances whenever it is empty or the stage after
// it moves, so bubbles are squeezed out under stall.
// Reset clears the valid bits only; data registers are not reset.
// ----------------------------------------------------------------------------
module aes_encrypt_round_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [63:0] state_high,
	input  wire logic [63:0] state_low,
	input  wire logic [63:0] key_high,
	input  wire logic [63:0] key_low,
	input  wire logic        last_round,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [63:0]      out_high,
	output logic [63:0]      out_low
);

	logic             valid_s1, valid_s2, valid_s3;
	logic             adv_s1, adv_s2, adv_s3;
	aesr_pkg::block_t state_s1, key_s1, key_s2, sh_s2, res_s3, mixed;
	logic             last_s1, last_s2;
	aesr_pkg::block_t sh;

	// Stage advance: a slot takes new data when empty or when it drains.
	assign adv_s3   = !valid_s3 || !out_stall;
	assign adv_s2   = !valid_s2 || adv_s3;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_stall = !adv_s1;

	// Valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (adv_s1) valid_s1 <= in_valid;
			if (adv_s2) valid_s2 <= valid_s1;
			if (adv_s3) valid_s3 <= valid_s2;
		end
	end

	// Stage 1: capture the item.
	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			state_s1 <= {state_high, state_low};
			key_s1   <= {key_high, key_low};
			last_s1  <= last_round;
		end
	end

	// SubBytes with row r rotated left by r.
	always_comb begin
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 4; c++) begin
				sh[r * 4 + c] = aesr_pkg::SBOX[state_s1[r * 4 + ((c + r) & 3)]];
			end
		end
	end

	// Stage 2: substituted and shifted state.
	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			sh_s2   <= sh;
			key_s2  <= key_s1;
			last_s2 <= last_s1;
		end
	end

	aesr_mix u_mix (
		.sh         (sh_s2),
		.key        (key_s2),
		.last_round (last_s2),
		.result     (mixed)
	);

	// Stage 3: output register.
	always_ff @(posedge clk) begin
		if (adv_s3 && valid_s2) begin
			res_s3 <= mixed;
		end
	end

	assign out_valid = valid_s3;
	assign out_high  = res_s3[0:7];
	assign out_low   = res_s3[8:15];

`ifndef ASSERT_OFF
	// Input backpressure only happens with every stage occupied.
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && valid_s3))
		else $error("input stalled with a free pipeline slot");

	// An accepted item lands in the first stage.
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> valid_s1)
		else $error("accepted item lost at stage 1");

	// A delivered result is replaced when the stage behind it holds an item.
	a_refill: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && !out_stall && valid_s2) |=> valid_s3)
		else $error("output stage not refilled");
`endif

endmodule
`default_nettype wire

### hw/rtl/aesr_mix.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aesr_mix
// MixColumns over all four columns, bypassed on the final round, then
// AddRoundKey.
// ----------------------------------------------------------------------------
module aesr_mix (
	input  wire aesr_pkg::block_t sh,
	input  wire aesr_pkg::block_t key,
	input  wire logic             last_round,
	output aesr_pkg::block_t      result
);

	aesr_pkg::block_t mx;

	// Column mix: each column times {02 03 01 01} as a circulant matrix.
	always_comb begin
		logic [7:0] a0, a1, a2, a3, d0, d1, d2, d3;
		mx = sh;
		for (int c = 0; c < 4; c++) begin
			a0 = sh[c];
			a1 = sh[c + 4];
			a2 = sh[c + 8];
			a3 = sh[c + 12];
			d0 = aesr_pkg::xtime(a0);
			d1 = aesr_pkg::xtime(a1);
			d2 = aesr_pkg::xtime(a2);
			d3 = aesr_pkg::xtime(a3);
			if (!last_round) begin
				mx[c]      = d0 ^ d1 ^ a1 ^ a2 ^ a3;
				mx[c + 4]  = a0 ^ d1 ^ d2 ^ a2 ^ a3;
				mx[c + 8]  = a0 ^ a1 ^ d2 ^ d3 ^ a3;
				mx[c + 12] = d0 ^ a0 ^ a1 ^ a2 ^ d3;
			end
		end
	end

	// Round key addition.
	assign result = mx ^ key;

endmodule
`default_nettype wire
